>>> rtl/dtp_pkg.sv
// Date-time text parser: shared types, codes and small constant functions.
// Used by dtp_scan, dtp_check and datetime_text_parser. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package dtp_pkg;

	localparam logic [2:0] PH_SEC  = 3'd0;
	localparam logic [2:0] PH_MIN  = 3'd1;
	localparam logic [2:0] PH_HOUR = 3'd2;
	localparam logic [2:0] PH_DAY  = 3'd3;
	localparam logic [2:0] PH_MON  = 3'd4;
	localparam logic [2:0] PH_YEAR = 3'd5;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_FAIL  = 2'd1;
	localparam logic [1:0] ST_BLANK = 2'd2;

	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_DASH  = 8'h2D;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;

	localparam int NUM_SMALL = 5;
	localparam logic [6:0]  SMALL_LIMIT = 7'd127;
	localparam logic [17:0] YEAR_LIMIT  = 18'd16383;

	// One finished parse, handed from the scanner to the checker.
	typedef struct packed {
		logic        blank;
		logic        failed;
		logic [5:0]  present;
		logic [13:0] year;
		logic        year_c100;  // year % 100 == 0
		logic [1:0]  year_r4;    // (year / 100) % 4
		logic [6:0]  month;
		logic [6:0]  day;
		logic [6:0]  hour;
		logic [6:0]  minute;
		logic [6:0]  second;
	} cand_t;

	// digit times ten to the place, places 0..4; higher places give 0
	function automatic logic [16:0] place_value(input logic [3:0] d, input logic [2:0] p);
		logic [16:0] v;
		case (p)
			3'd0: v = 17'(d);
			3'd1: v = 17'(d) * 17'd10;
			3'd2: v = 17'(d) * 17'd100;
			3'd3: v = 17'(d) * 17'd1000;
			3'd4: v = 17'(d) * 17'd10000;
			default: v = 17'd0;
		endcase
		return v;
	endfunction

	function automatic logic [4:0] month_days(input logic [3:0] m, input logic leap);
		logic [4:0] n;
		case (m)
			4'd4, 4'd6, 4'd9, 4'd11: n = 5'd30;
			4'd2: n = leap ? 5'd29 : 5'd28;
			4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: n = 5'd31;
			default: n = 5'd0;
		endcase
		return n;
	endfunction

endpackage

`default_nettype wire

>>> rtl/dtp_scan.sv
// Date-time text parser: character scanner, one beat per cycle while accept is high.
// Builds the field accumulators and registers a candidate on the final beat. Uses dtp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dtp_scan (
	input  wire              clk,
	input  wire              arst_n,
	input  wire              en,
	input  wire              accept,
	input  wire  [7:0]       char_code,
	input  wire              is_final,
	output logic             cand_valid_s2,
	output dtp_pkg::cand_t   cand_s2
);

	logic [2:0]  phase_q, phase_n;
	logic [13:0] year_q, year_n;
	logic [6:0]  acc_q [dtp_pkg::NUM_SMALL];
	logic [6:0]  acc_n [dtp_pkg::NUM_SMALL];
	logic [5:0]  pres_q, pres_n;
	logic [2:0]  place_q, place_n;
	logic        started_q, started_n;
	logic        done_q, done_n;
	logic        failed_q, failed_n;
	logic        c100_q, c100_n;
	logic [1:0]  r4_q, r4_n;

	logic [3:0]  dig;
	logic [16:0] pval;
	logic [9:0]  small_sum;
	logic [17:0] year_sum;
	logic [2:0]  aidx;

	assign dig  = char_code[3:0];
	assign pval = dtp_pkg::place_value(dig, place_q);
	assign aidx = (phase_q < dtp_pkg::PH_YEAR) ? phase_q : dtp_pkg::PH_SEC;
	assign small_sum = 10'(acc_q[aidx]) + pval[9:0];
	assign year_sum  = 18'(year_q) + 18'(pval);

	always_comb begin
		phase_n   = phase_q;
		year_n    = year_q;
		acc_n     = acc_q;
		pres_n    = pres_q;
		place_n   = place_q;
		started_n = started_q;
		done_n    = done_q;
		failed_n  = failed_q;
		c100_n    = c100_q;
		r4_n      = r4_q;
		if (!done_q && (started_q || char_code != dtp_pkg::CH_SPACE)) begin
			started_n = 1'b1;
			if (char_code >= dtp_pkg::CH_ZERO && char_code <= dtp_pkg::CH_NINE) begin
				if (phase_q < dtp_pkg::PH_YEAR) begin
					if ((dig != 4'd0 && place_q >= 3'd3) ||
					    small_sum > 10'(dtp_pkg::SMALL_LIMIT)) begin
						failed_n = 1'b1;
						done_n   = 1'b1;
					end else begin
						acc_n[aidx] = small_sum[6:0];
						pres_n[phase_q] = 1'b1;
						place_n = (place_q < 3'd7) ? place_q + 3'd1 : 3'd7;
					end
				end else if (phase_q == dtp_pkg::PH_YEAR) begin
					if ((dig != 4'd0 && place_q >= 3'd5) || year_sum > dtp_pkg::YEAR_LIMIT) begin
						failed_n = 1'b1;
						done_n   = 1'b1;
					end else begin
						year_n = year_sum[13:0];
						pres_n[dtp_pkg::PH_YEAR] = 1'b1;
						place_n = (place_q < 3'd7) ? place_q + 3'd1 : 3'd7;
						case (place_q)
							3'd0, 3'd1: if (dig != 4'd0) c100_n = 1'b0;
							3'd2: r4_n = r4_q + dig[1:0];
							3'd3: r4_n = r4_q + {dig[0], 1'b0};
							default: r4_n = r4_q;
						endcase
					end
				end else begin
					failed_n = 1'b1;
					done_n   = 1'b1;
				end
			end else if (char_code == dtp_pkg::CH_DASH || char_code == dtp_pkg::CH_SLASH) begin
				place_n = 3'd0;
				case (phase_q)
					dtp_pkg::PH_SEC: begin
						acc_n[dtp_pkg::PH_DAY] = acc_q[dtp_pkg::PH_SEC];
						acc_n[dtp_pkg::PH_SEC] = 7'd0;
						pres_n[dtp_pkg::PH_DAY] = pres_q[dtp_pkg::PH_SEC];
						pres_n[dtp_pkg::PH_SEC] = 1'b0;
						phase_n = dtp_pkg::PH_MON;
					end
					dtp_pkg::PH_DAY: phase_n = dtp_pkg::PH_MON;
					dtp_pkg::PH_MON: phase_n = dtp_pkg::PH_YEAR;
					default: begin
						place_n  = place_q;
						failed_n = 1'b1;
						done_n   = 1'b1;
					end
				endcase
			end else if (char_code == dtp_pkg::CH_COLON) begin
				place_n = 3'd0;
				case (phase_q)
					dtp_pkg::PH_SEC: phase_n = dtp_pkg::PH_MIN;
					dtp_pkg::PH_MIN: phase_n = dtp_pkg::PH_HOUR;
					default: begin
						place_n  = place_q;
						failed_n = 1'b1;
						done_n   = 1'b1;
					end
				endcase
			end else if (char_code == dtp_pkg::CH_SPACE) begin
				case (phase_q)
					dtp_pkg::PH_HOUR: begin
						phase_n = dtp_pkg::PH_DAY;
						place_n = 3'd0;
					end
					dtp_pkg::PH_YEAR: done_n = 1'b1;
					default: begin
						failed_n = 1'b1;
						done_n   = 1'b1;
					end
				endcase
			end else begin
				failed_n = 1'b1;
				done_n   = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= dtp_pkg::PH_SEC;
			year_q    <= '0;
			for (int i = 0; i < dtp_pkg::NUM_SMALL; i++) acc_q[i] <= '0;
			pres_q    <= '0;
			place_q   <= '0;
			started_q <= 1'b0;
			done_q    <= 1'b0;
			failed_q  <= 1'b0;
			c100_q    <= 1'b1;
			r4_q      <= '0;
		end else if (accept) begin
			if (is_final) begin
				phase_q   <= dtp_pkg::PH_SEC;
				year_q    <= '0;
				for (int i = 0; i < dtp_pkg::NUM_SMALL; i++) acc_q[i] <= '0;
				pres_q    <= '0;
				place_q   <= '0;
				started_q <= 1'b0;
				done_q    <= 1'b0;
				failed_q  <= 1'b0;
				c100_q    <= 1'b1;
				r4_q      <= '0;
			end else begin
				phase_q   <= phase_n;
				year_q    <= year_n;
				acc_q     <= acc_n;
				pres_q    <= pres_n;
				place_q   <= place_n;
				started_q <= started_n;
				done_q    <= done_n;
				failed_q  <= failed_n;
				c100_q    <= c100_n;
				r4_q      <= r4_n;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cand_valid_s2 <= 1'b0;
		end else if (en) begin
			cand_valid_s2 <= accept && is_final;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && is_final) begin
			cand_s2.blank     <= !started_n;
			cand_s2.failed    <= failed_n;
			cand_s2.present   <= pres_n;
			cand_s2.year      <= year_n;
			cand_s2.year_c100 <= c100_n;
			cand_s2.year_r4   <= r4_n;
			cand_s2.month     <= acc_n[dtp_pkg::PH_MON];
			cand_s2.day       <= acc_n[dtp_pkg::PH_DAY];
			cand_s2.hour      <= acc_n[dtp_pkg::PH_HOUR];
			cand_s2.minute    <= acc_n[dtp_pkg::PH_MIN];
			cand_s2.second    <= acc_n[dtp_pkg::PH_SEC];
		end
	end

endmodule

`default_nettype wire

>>> rtl/dtp_check.sv
// Date-time text parser: merge with the stored date-time, Gregorian check, result register.
// Holds the stored date-time. Uses dtp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dtp_check (
	input  wire             clk,
	input  wire             arst_n,
	input  wire             en,
	input  wire             cand_valid,
	input  wire dtp_pkg::cand_t cand,
	output logic            out_valid_q,
	output logic [1:0]      status_q,
	output logic [13:0]     year_out_q,
	output logic [3:0]      month_out_q,
	output logic [4:0]      day_out_q,
	output logic [4:0]      hour_out_q,
	output logic [5:0]      minute_out_q,
	output logic [5:0]      second_out_q
);

	logic [13:0] kyear_q;
	logic [3:0]  kmonth_q;
	logic [4:0]  kday_q;
	logic [4:0]  khour_q;
	logic [5:0]  kminute_q;
	logic [5:0]  ksecond_q;
	logic        kc100_q;
	logic [1:0]  kr4_q;

	logic        use_year;
	logic [13:0] y;
	logic        c100;
	logic [1:0]  r4;
	logic [6:0]  mo, d, h, mi, s;
	logic        leap, ok;
	logic [4:0]  mdays;
	logic [1:0]  status;

	always_comb begin
		use_year = cand.present[dtp_pkg::PH_YEAR] && cand.year != 14'd0;
		y    = use_year ? cand.year : kyear_q;
		c100 = use_year ? cand.year_c100 : kc100_q;
		r4   = use_year ? cand.year_r4 : kr4_q;
		mo = (cand.present[dtp_pkg::PH_MON] && cand.month != 7'd0) ? cand.month : 7'(kmonth_q);
		d  = (cand.present[dtp_pkg::PH_DAY] && cand.day != 7'd0) ? cand.day : 7'(kday_q);
		h  = cand.present[dtp_pkg::PH_HOUR] ? cand.hour : 7'(khour_q);
		mi = cand.present[dtp_pkg::PH_MIN] ? cand.minute : 7'(kminute_q);
		s  = cand.present[dtp_pkg::PH_SEC] ? cand.second : 7'(ksecond_q);
		leap  = (y[1:0] == 2'd0 && !c100) || (c100 && r4 == 2'd0);
		mdays = dtp_pkg::month_days(mo[3:0], leap);
		ok = y >= 14'd1 && y <= 14'd9999 && mo >= 7'd1 && mo <= 7'd12 &&
		     d >= 7'd1 && d <= 7'(mdays) && h < 7'd24 && mi < 7'd60 && s < 7'd60;
		if (cand.blank)
			status = dtp_pkg::ST_BLANK;
		else if (cand.failed || !ok)
			status = dtp_pkg::ST_FAIL;
		else
			status = dtp_pkg::ST_OK;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kyear_q   <= '0;
			kmonth_q  <= '0;
			kday_q    <= '0;
			khour_q   <= '0;
			kminute_q <= '0;
			ksecond_q <= '0;
			kc100_q   <= 1'b1;
			kr4_q     <= '0;
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= cand_valid;
			if (cand_valid) begin
				case (status)
					dtp_pkg::ST_OK: begin
						kyear_q   <= y;
						kmonth_q  <= mo[3:0];
						kday_q    <= d[4:0];
						khour_q   <= h[4:0];
						kminute_q <= mi[5:0];
						ksecond_q <= s[5:0];
						kc100_q   <= c100;
						kr4_q     <= r4;
					end
					dtp_pkg::ST_FAIL: begin
						kyear_q   <= '0;
						kmonth_q  <= '0;
						kday_q    <= '0;
						khour_q   <= '0;
						kminute_q <= '0;
						ksecond_q <= '0;
						kc100_q   <= 1'b1;
						kr4_q     <= '0;
					end
					default: kyear_q <= kyear_q;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en && cand_valid) begin
			status_q <= status;
			case (status)
				dtp_pkg::ST_OK: begin
					year_out_q   <= y;
					month_out_q  <= mo[3:0];
					day_out_q    <= d[4:0];
					hour_out_q   <= h[4:0];
					minute_out_q <= mi[5:0];
					second_out_q <= s[5:0];
				end
				dtp_pkg::ST_FAIL: begin
					year_out_q   <= '0;
					month_out_q  <= '0;
					day_out_q    <= '0;
					hour_out_q   <= '0;
					minute_out_q <= '0;
					second_out_q <= '0;
				end
				default: begin
					year_out_q   <= kyear_q;
					month_out_q  <= kmonth_q;
					day_out_q    <= kday_q;
					hour_out_q   <= khour_q;
					minute_out_q <= kminute_q;
					second_out_q <= ksecond_q;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

>>> rtl/datetime_text_parser.sv
// Date-time text parser, top level: stream ports around scanner and checker.
// Instantiates dtp_scan and dtp_check; uses dtp_pkg.
//
// Characters of a "Y-M-D h:m:s" string come in one beat per cycle, last character
// first, with tlast on the string's first character. Each beat updates small field
// accumulators; the tlast beat produces one result beat, registered first in the candidate
// register and then, after merge/check, in the output register, giving status and the
// stored date-time. A new character is taken every cycle while the output side is not
// stalled; s_tready follows the output register being free or being drained.
`timescale 1ns / 1ps
`default_nettype none

module datetime_text_parser (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_tvalid,
	output logic        s_tready,
	input  wire  [7:0]  s_tdata,   // [7:0] char_code
	input  wire         s_tlast,   // is_final
	output logic        m_tvalid,
	input  wire         m_tready,
	output logic [39:0] m_tdata,   // year_out, month_out, day_out, hour_out, minute_out, second_out
	output logic [1:0]  m_tuser    // status
);

	logic           en;
	logic           accept;
	logic           cand_valid_s2;
	dtp_pkg::cand_t cand_s2;
	logic [13:0]    year_out;
	logic [3:0]     month_out;
	logic [4:0]     day_out;
	logic [4:0]     hour_out;
	logic [5:0]     minute_out;
	logic [5:0]     second_out;

	assign en       = !m_tvalid || m_tready;
	assign s_tready = en;
	assign accept   = s_tvalid && en;

	dtp_scan u_scan (
		.clk           (clk),
		.arst_n        (arst_n),
		.en            (en),
		.accept        (accept),
		.char_code     (s_tdata),
		.is_final      (s_tlast),
		.cand_valid_s2 (cand_valid_s2),
		.cand_s2       (cand_s2)
	);

	dtp_check u_check (
		.clk          (clk),
		.arst_n       (arst_n),
		.en           (en),
		.cand_valid   (cand_valid_s2),
		.cand         (cand_s2),
		.out_valid_q  (m_tvalid),
		.status_q     (m_tuser),
		.year_out_q   (year_out),
		.month_out_q  (month_out),
		.day_out_q    (day_out),
		.hour_out_q   (hour_out),
		.minute_out_q (minute_out),
		.second_out_q (second_out)
	);

	assign m_tdata = {second_out, minute_out, hour_out, day_out, month_out, year_out};

endmodule

`default_nettype wire
